FILE: rtl/core/hsp_pkg.sv
// Shared types and constants for the half-sample image pyramid.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package hsp_pkg;

  // Parameter defaults
  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned MaxLevelsDef = 8;

  // Fixed field widths
  localparam int unsigned CfgW    = 12;  // width and height registers
  localparam int unsigned LvlCfgW = 4;   // level count register
  localparam int unsigned RowW    = 12;  // row counters follow the 12-bit height
  localparam int unsigned PixW    = 8;
  localparam int unsigned PairW   = 9;
  localparam int unsigned OutLvlW = 3;
  localparam int unsigned OutPosW = 10;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLevels = 2'd2;

  // Register reset values
  localparam logic [CfgW-1:0]    WidthRst  = 12'd640;
  localparam logic [CfgW-1:0]    HeightRst = 12'd480;
  localparam logic [LvlCfgW-1:0] LevelsRst = 4'd4;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take the input item, start at level 0
    logic eval;     // step the current level's filter
    logic advance;  // finish the average, move one level up
    logic emit;     // move the pending result into the output register
    logic last;     // flag for the emitted result
    logic finish;   // end of the item: apply end-of-frame clear
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic first_ok;  // more than one level in use
    logic next_ok;   // a level above the one just produced is in use
    logic produce;   // current level completes a 2x2 block
    logic pend;      // a result waits to be emitted
    logic out_free;  // output register can take a result
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/hsp_ctrl.sv
// Controller for the half-sample pyramid: walks the levels of one item.
// Depends on hsp_pkg (state_e, cmd_t, status_t).
`default_nettype none

module hsp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire hsp_pkg::status_t st_i,
  output hsp_pkg::cmd_t        cmd_o
);

  hsp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      hsp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (st_i.first_ok) begin
            state_d = hsp_pkg::S_EVAL;
          end
        end
      end
      hsp_pkg::S_EVAL: begin
        // hold off while a pending result cannot leave
        if (!st_i.pend || st_i.out_free) begin
          cmd_o.eval = 1'b1;
          cmd_o.emit = st_i.pend;
          cmd_o.last = !st_i.produce;
          if (st_i.produce) begin
            state_d = hsp_pkg::S_READ;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = hsp_pkg::S_IDLE;
          end
        end
      end
      hsp_pkg::S_READ: begin
        cmd_o.advance = 1'b1;
        state_d = st_i.next_ok ? hsp_pkg::S_EVAL : hsp_pkg::S_DONE;
      end
      hsp_pkg::S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.last   = 1'b1;
          cmd_o.finish = 1'b1;
          state_d      = hsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = hsp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/hsp_datapath.sv
// Datapath for the half-sample pyramid: per-level counters, left pixels,
// pair-sum memory, pending result and output register. Depends on hsp_pkg.
`default_nettype none

module hsp_datapath #(
  parameter int unsigned MAX_WIDTH  = hsp_pkg::MaxWidthDef,
  parameter int unsigned MAX_LEVELS = hsp_pkg::MaxLevelsDef,
  localparam int unsigned CW  = $clog2(MAX_WIDTH),
  localparam int unsigned NLW = $clog2(MAX_LEVELS + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [CW:0]                wid0_i,
  input  wire logic [hsp_pkg::CfgW-1:0]   hgt0_i,
  input  wire logic [NLW-1:0]             nlev_i,
  input  wire logic [hsp_pkg::PixW-1:0]   in_pixel_i,
  input  wire hsp_pkg::cmd_t              cmd_i,
  output hsp_pkg::status_t                st_o,
  input  wire logic                       out_stall_i,
  output logic                            out_valid_o,
  output logic [hsp_pkg::OutLvlW-1:0]     out_level_o,
  output logic [hsp_pkg::PixW-1:0]        out_pixel_o,
  output logic [hsp_pkg::OutPosW-1:0]     out_col_o,
  output logic [hsp_pkg::OutPosW-1:0]     out_row_o,
  output logic                            last_of_run_o
);

  localparam int unsigned LVW = $clog2(MAX_LEVELS);
  localparam int unsigned RW  = hsp_pkg::RowW;

  // Per-level state
  logic [CW-1:0]            col_q  [MAX_LEVELS];
  logic [RW-1:0]            row_q  [MAX_LEVELS];
  logic [hsp_pkg::PixW-1:0] held_q [MAX_LEVELS];

  // Pair-sum memory
  logic [hsp_pkg::PairW-1:0] mem [MAX_WIDTH];
  logic [hsp_pkg::PairW-1:0] rdata_q;

  // Walk registers for the item in flight
  logic [hsp_pkg::PixW-1:0]  v_q;
  logic [LVW-1:0]            lv_q;
  logic [CW:0]               wid_q, base_q;
  logic [RW-1:0]             hgt_q;
  logic                      fend_q;
  logic [hsp_pkg::PairW-1:0] pair_q;
  logic [CW-1:0]             c_q;
  logic [RW-1:0]             r_q;

  // Pending result
  logic                        pend_q;
  logic [hsp_pkg::OutLvlW-1:0] p_lvl_q;
  logic [hsp_pkg::PixW-1:0]    p_pix_q;
  logic [hsp_pkg::OutPosW-1:0] p_col_q, p_row_q;

  // Output register
  logic                        ov_q;
  logic [hsp_pkg::OutLvlW-1:0] o_lvl_q;
  logic [hsp_pkg::PixW-1:0]    o_pix_q;
  logic [hsp_pkg::OutPosW-1:0] o_col_q, o_row_q;
  logic                        o_last_q;

  // Current level view
  logic [CW-1:0]             c;
  logic [RW-1:0]             r;
  logic [CW:0]               wn;
  logic                      wrap, in_blk, fend_now, fend;
  logic [CW-1:0]             c_nx;
  logic [RW-1:0]             r_nx;
  logic [hsp_pkg::PairW-1:0] pair;
  logic [CW-1:0]             idx;
  logic [CW:0]               idx_full;
  logic [hsp_pkg::PairW:0]   sum4;
  logic [31:0]               lvl_full, col_full, row_full;

  always_comb begin
    c        = col_q[lv_q];
    r        = row_q[lv_q];
    wn       = wid_q >> 1;
    wrap     = ({1'b0, c} + {{CW{1'b0}}, 1'b1}) >= wid_q;
    c_nx     = wrap ? '0 : c + {{(CW-1){1'b0}}, 1'b1};
    r_nx     = wrap ? r + {{(RW-1){1'b0}}, 1'b1} : r;
    // inside the even-sized part of the level
    in_blk   = ({1'b0, c} < (wid_q & ~{{CW{1'b0}}, 1'b1})) &&
               (r < (hgt_q & ~{{(RW-1){1'b0}}, 1'b1}));
    pair     = {1'b0, held_q[lv_q]} + {1'b0, v_q};
    idx_full = base_q + {1'b0, c >> 1};
    idx      = idx_full[CW-1:0];
    fend_now = r_nx >= hgt_q;
    fend     = (cmd_i.eval && (lv_q == '0)) ? fend_now : fend_q;
    sum4     = {1'b0, rdata_q} + {1'b0, pair_q};
    lvl_full = 32'(lv_q) + 32'd1;
    col_full = 32'(c_q >> 1);
    row_full = 32'(r_q >> 1);
  end

  // Status to the controller
  always_comb begin
    st_o.first_ok = 32'(nlev_i) > 32'd1;
    st_o.next_ok  = (32'(lv_q) + 32'd2) < 32'(nlev_i);
    st_o.produce  = in_blk && c[0] && r[0];
    st_o.pend     = pend_q;
    st_o.out_free = !ov_q || !out_stall_i;
  end

  // Per-level counters and left pixels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_q[i]  <= '0;
        row_q[i]  <= '0;
        held_q[i] <= '0;
      end
    end else begin
      // end of frame wins over the step's update
      if (cmd_i.finish && fend) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          col_q[i] <= '0;
          row_q[i] <= '0;
        end
      end else if (cmd_i.eval) begin
        col_q[lv_q] <= c_nx;
        row_q[lv_q] <= r_nx;
      end
      if (cmd_i.eval && in_blk && !c[0]) begin
        held_q[lv_q] <= v_q;
      end
    end
  end

  // Pair-sum memory: even rows write, odd rows read
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && in_blk && c[0] && !r[0]) begin
      mem[idx] <= pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && in_blk && c[0] && r[0]) begin
      rdata_q <= mem[idx];
    end
  end

  // Walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q   <= '0;
      fend_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        lv_q   <= '0;
        fend_q <= 1'b0;
      end else if (cmd_i.advance) begin
        lv_q <= lv_q + {{(LVW-1){1'b0}}, 1'b1};
      end
      if (cmd_i.eval && (lv_q == '0)) begin
        fend_q <= fend_now;
      end
      if (cmd_i.advance) begin
        pend_q <= 1'b1;
      end else if (cmd_i.emit) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q    <= in_pixel_i;
      wid_q  <= wid0_i;
      hgt_q  <= hgt0_i;
      base_q <= '0;
    end else if (cmd_i.advance) begin
      v_q    <= sum4[hsp_pkg::PairW:2];
      wid_q  <= wn;
      hgt_q  <= hgt_q >> 1;
      base_q <= base_q + wn;
    end
    if (cmd_i.eval) begin
      pair_q <= pair;
      c_q    <= c;
      r_q    <= r;
    end
    if (cmd_i.advance) begin
      p_lvl_q <= lvl_full[hsp_pkg::OutLvlW-1:0];
      p_pix_q <= sum4[hsp_pkg::PairW:2];
      p_col_q <= col_full[hsp_pkg::OutPosW-1:0];
      p_row_q <= row_full[hsp_pkg::OutPosW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      o_lvl_q  <= p_lvl_q;
      o_pix_q  <= p_pix_q;
      o_col_q  <= p_col_q;
      o_row_q  <= p_row_q;
      o_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_level_o   = o_lvl_q;
  assign out_pixel_o   = o_pix_q;
  assign out_col_o     = o_col_q;
  assign out_row_o     = o_row_q;
  assign last_of_run_o = o_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/half_sample_image_pyramid.sv
// Half-sample image pyramid top level: configuration registers and clamping,
// controller and datapath. Depends on hsp_pkg, hsp_ctrl and hsp_datapath.
//
// Usage: level-0 pixels enter in raster order on in_valid_i/in_stall_o/
// in_pixel_i. For each pixel the block emits every downsampled pixel it
// completes on levels 1 .. num_levels-1, lowest level first, each with its
// level, column and row; last_of_run_o marks the final result of a pixel.
// A pixel that completes nothing yields no result.
// Timing: a pixel is loaded and then walked level by level; each result adds a
// pair-sum memory read, then a hand-off overlapped with the next level's
// evaluate, set by the one-port pair-sum memory and the level-by-level walk.
// A new pixel is taken once the last level of the previous one has been
// handled.
// Output: a result register drives out_*; while out_stall_i is high it holds
// and the walk waits before handing over the next result.
// Configuration: cfg_ready_o is always high; write only while idle.
// Reset: registers return to 640 x 480 with 4 levels and all counters clear;
// the pair-sum memory needs no clearing since even rows write before odd
// rows read.
`default_nettype none

module half_sample_image_pyramid #(
  parameter int unsigned MAX_WIDTH  = hsp_pkg::MaxWidthDef,
  parameter int unsigned MAX_LEVELS = hsp_pkg::MaxLevelsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [hsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [hsp_pkg::CfgW-1:0]    cfg_data_i,
  // input items
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [hsp_pkg::PixW-1:0]    in_pixel_i,
  // result items
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [hsp_pkg::OutLvlW-1:0]      out_level_o,
  output logic [hsp_pkg::PixW-1:0]         out_pixel_o,
  output logic [hsp_pkg::OutPosW-1:0]      out_col_o,
  output logic [hsp_pkg::OutPosW-1:0]      out_row_o,
  output logic                             last_of_run_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned NLW = $clog2(MAX_LEVELS + 1);

  logic [hsp_pkg::CfgW-1:0]    width_q, height_q;
  logic [hsp_pkg::LvlCfgW-1:0] levels_q;

  logic [CW:0]              wid0;
  logic [hsp_pkg::CfgW-1:0] hgt0;
  logic [NLW-1:0]           nlev;
  logic [31:0]              w32, l32, wsel, lsel;

  hsp_pkg::cmd_t    cmd;
  hsp_pkg::status_t st;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hsp_pkg::WidthRst;
      height_q <= hsp_pkg::HeightRst;
      levels_q <= hsp_pkg::LevelsRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        hsp_pkg::RegWidth:  width_q  <= cfg_data_i;
        hsp_pkg::RegHeight: height_q <= cfg_data_i;
        hsp_pkg::RegLevels: levels_q <= cfg_data_i[hsp_pkg::LvlCfgW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and level count
  always_comb begin
    w32  = 32'(width_q);
    l32  = 32'(levels_q);
    wsel = (w32 < 32'd2) ? 32'd2 : ((w32 > MAX_WIDTH) ? 32'(MAX_WIDTH) : w32);
    lsel = (l32 < 32'd1) ? 32'd1 : ((l32 > MAX_LEVELS) ? 32'(MAX_LEVELS) : l32);
    wid0 = wsel[CW:0];
    nlev = lsel[NLW-1:0];
    hgt0 = (height_q < hsp_pkg::CfgW'(2)) ? hsp_pkg::CfgW'(2) : height_q;
  end

  hsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  hsp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wid0_i        (wid0),
    .hgt0_i        (hgt0),
    .nlev_i        (nlev),
    .in_pixel_i    (in_pixel_i),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_level_o   (out_level_o),
    .out_pixel_o   (out_pixel_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire
